FILE: design/hall_key_rapid_trigger_defines.svh
// Assertion macros used by the key tracker's top module.
`ifndef HALL_KEY_RAPID_TRIGGER_DEFINES_SVH
`define HALL_KEY_RAPID_TRIGGER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HKRT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HKRT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/hkrt_pkg.sv
`timescale 1ns / 1ps

package hkrt_pkg;

    localparam int ROWS_DEF = 8;
    localparam int KEYS_DEF = 16;

    localparam int ACTION_W = 2;
    localparam int ROW_W    = 3;
    localparam int COL_W    = 4;
    localparam int SAMPLE_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    localparam logic [ACTION_W-1:0] ACT_SCAN = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BASE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ACTU = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RAPID_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_DIST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_RUNS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_RUNS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT = 3'd4;

    localparam logic [SAMPLE_W-1:0] CONNECT_LIMIT = 8'h7F;

    localparam logic       RAPID_ENABLE_RST = 1'b1;
    localparam logic [7:0] TRIGGER_DIST_RST = 8'd10;
    localparam logic [7:0] DIRECTION_RUNS_RST = 8'd2;
    localparam logic [7:0] IDLE_RUNS_RST = 8'd8;
    localparam logic [7:0] JUMP_LIMIT_RST = 8'd20;

    typedef enum logic [1:0] {
        MOT_IDLE    = 2'd0,
        MOT_PRESS   = 2'd1,
        MOT_RELEASE = 2'd2
    } motion_t;

    typedef struct packed {
        logic       rapid_enable;
        logic [7:0] trigger_distance;
        logic [7:0] direction_runs;
        logic [7:0] idle_runs;
        logic [7:0] jump_limit;
    } cfg_t;

    // All-zero is the reset value of every key's entry.
    typedef struct packed {
        logic [7:0] prev_sample;
        logic [7:0] baseline;
        logic [7:0] actuation_point;
        logic [7:0] peak;
        logic [7:0] trough;
        logic [7:0] peak_candidate;
        logic [7:0] trough_candidate;
        logic [7:0] idle_count;
        logic [7:0] press_count;
        logic [7:0] release_count;
        motion_t    motion_state;
        logic       key_down;
    } key_state_t;

endpackage

FILE: design/hall_key_rapid_trigger.sv
`timescale 1ns / 1ps

// Rapid-trigger tracker for a matrix of analogue Hall-effect keys.
// An input item names a key by row and column and either scans a sensor
// sample, loads the key's baseline or loads its actuation point. Each item
// gives exactly one result item: the key's address, its pressed flag and
// motion state after the item, and whether the key is connected.
// Both item channels use valid and stall; an item moves on a rising edge
// with valid high and stall low. Configuration is written through a
// separate valid/ready port that is always ready; the user must write it
// only while idle, which the block does not enforce. One item is accepted
// every cycle unless the input is stalled. Per-key state sits in a single
// memory with one read and one write port; a key is read in the acceptance
// cycle and written back as its item leaves the update stage, and a write
// to the key being read in that cycle is forwarded into the read data.
// When the receiver stalls, the result register holds and the one item in
// the update stage waits behind it; only then is the input stalled. Reset
// clears the configuration to its defaults and marks every key's entry as
// zero (released and idle) through per-key valid bits, so the block is
// ready at once with no clearing pass.
module hall_key_rapid_trigger #(
    parameter int ROWS = hkrt_pkg::ROWS_DEF,
    parameter int KEYS_PER_ROW = hkrt_pkg::KEYS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [hkrt_pkg::ACTION_W-1:0]   action,
    input  logic [hkrt_pkg::ROW_W-1:0]      row,
    input  logic [hkrt_pkg::COL_W-1:0]      column,
    input  logic [hkrt_pkg::SAMPLE_W-1:0]   sample,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [hkrt_pkg::ROW_W-1:0]      row_out,
    output logic [hkrt_pkg::COL_W-1:0]      column_out,
    output logic                            pressed,
    output logic [1:0]                      motion,
    output logic                            connected,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hkrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hkrt_pkg::CFG_DAT_W-1:0]  cfg_data
);

`include "hall_key_rapid_trigger_defines.svh"

    localparam int NKEYS = ROWS * KEYS_PER_ROW;
    localparam int KW = (NKEYS > 1) ? $clog2(NKEYS) : 1;

    hkrt_pkg::cfg_t cfg_reg;
    hkrt_pkg::cfg_t cfg_next;

    logic                            accept;
    logic                            in_range;
    logic [7:0]                      key_full;
    logic                            s1_adv;
    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic                            s1_inrange_reg;
    logic [KW-1:0]                   s1_key_reg;
    logic [hkrt_pkg::ACTION_W-1:0]   s1_action_reg;
    logic [hkrt_pkg::ROW_W-1:0]      s1_row_reg;
    logic [hkrt_pkg::COL_W-1:0]      s1_col_reg;
    logic [hkrt_pkg::SAMPLE_W-1:0]   s1_sample_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [hkrt_pkg::ROW_W-1:0]      row_out_reg;
    logic [hkrt_pkg::COL_W-1:0]      column_out_reg;
    logic                            pressed_reg;
    logic [1:0]                      motion_reg;
    logic                            connected_reg;
    hkrt_pkg::key_state_t            cur_state;
    hkrt_pkg::key_state_t            new_state;
    logic                            upd_connected;

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hkrt_pkg::REG_RAPID_ENABLE:   cfg_next.rapid_enable = cfg_data[0];
                hkrt_pkg::REG_TRIGGER_DIST:   cfg_next.trigger_distance = cfg_data;
                hkrt_pkg::REG_DIRECTION_RUNS: cfg_next.direction_runs = cfg_data;
                hkrt_pkg::REG_IDLE_RUNS:      cfg_next.idle_runs = cfg_data;
                hkrt_pkg::REG_JUMP_LIMIT:     cfg_next.jump_limit = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    // Key address: out-of-range keys never touch the memory.
    assign in_range = ({2'b00, row} < 5'(ROWS)) && ({1'b0, column} < 5'(KEYS_PER_ROW));
    assign key_full = 8'({5'b00000, row} * 8'(KEYS_PER_ROW)) + {4'b0000, column};

    // Pipeline control: the update stage drains into the result register
    // whenever that register is empty or being taken.
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    assign s1_valid_next  = accept || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rapid_enable     <= hkrt_pkg::RAPID_ENABLE_RST;
            cfg_reg.trigger_distance <= hkrt_pkg::TRIGGER_DIST_RST;
            cfg_reg.direction_runs   <= hkrt_pkg::DIRECTION_RUNS_RST;
            cfg_reg.idle_runs        <= hkrt_pkg::IDLE_RUNS_RST;
            cfg_reg.jump_limit       <= hkrt_pkg::JUMP_LIMIT_RST;
            s1_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_inrange_reg <= in_range;
            s1_key_reg     <= key_full[KW-1:0];
            s1_action_reg  <= action;
            s1_row_reg     <= row;
            s1_col_reg     <= column;
            s1_sample_reg  <= sample;
        end
        if (s1_adv)
        begin
            row_out_reg    <= s1_row_reg;
            column_out_reg <= s1_col_reg;
            pressed_reg    <= s1_inrange_reg && new_state.key_down;
            motion_reg     <= s1_inrange_reg ? new_state.motion_state : hkrt_pkg::MOT_IDLE;
            connected_reg  <= s1_inrange_reg && upd_connected;
        end
    end

    hkrt_mem #(
        .DEPTH (NKEYS),
        .AW    (KW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && in_range),
        .rd_addr (key_full[KW-1:0]),
        .wr_en   (s1_adv && s1_inrange_reg),
        .wr_addr (s1_key_reg),
        .wr_data (new_state),
        .rd_data (cur_state)
    );

    hkrt_update u_update (
        .cur       (cur_state),
        .cfg       (cfg_reg),
        .action    (s1_action_reg),
        .sample    (s1_sample_reg),
        .nxt       (new_state),
        .connected (upd_connected)
    );

    assign out_valid  = out_valid_reg;
    assign row_out    = row_out_reg;
    assign column_out = column_out_reg;
    assign pressed    = pressed_reg;
    assign motion     = motion_reg;
    assign connected  = connected_reg;

    `HKRT_ASSERT_IMP(a_out_of_range_quiet, clk, rst_n,
        out_valid && (({2'b00, row_out} >= 5'(ROWS)) || ({1'b0, column_out} >= 5'(KEYS_PER_ROW))),
        !pressed && motion == hkrt_pkg::MOT_IDLE && !connected,
        "out-of-range key reported with state")
    `HKRT_ASSERT_NXT(a_stage_holds, clk, rst_n,
        s1_valid_reg && !s1_adv,
        s1_valid_reg && $stable(s1_key_reg),
        "update stage lost its item while blocked")
    `HKRT_ASSERT_IMP(a_stall_cause, clk, rst_n,
        in_stall,
        s1_valid_reg && out_valid_reg && out_stall,
        "input stalled without a blocked result")

endmodule

FILE: design/hkrt_mem.sv
`timescale 1ns / 1ps

// Per-key state memory: one write and one read port, registered read data.
// Entries never written read as zero through valid bits, and a write to the
// entry being read in the same cycle is forwarded.
module hkrt_mem #(
    parameter int DEPTH = hkrt_pkg::ROWS_DEF * hkrt_pkg::KEYS_DEF,
    parameter int AW = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  hkrt_pkg::key_state_t  wr_data,
    output hkrt_pkg::key_state_t  rd_data
);

    hkrt_pkg::key_state_t mem [DEPTH];
    hkrt_pkg::key_state_t raw_reg;
    hkrt_pkg::key_state_t byp_reg;
    logic [DEPTH-1:0]     valid_reg;
    logic                 hit_reg;
    logic                 vld_rd_reg;
    logic                 hit_next;

    assign hit_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            raw_reg <= mem[rd_addr];
            byp_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            hit_reg    <= 1'b0;
            vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg    <= hit_next;
                vld_rd_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? byp_reg : (vld_rd_reg ? raw_reg : '0);

endmodule

FILE: design/hkrt_update.sv
`timescale 1ns / 1ps

// Next state of one key for one item, and its connected flag.
module hkrt_update (
    input  hkrt_pkg::key_state_t           cur,
    input  hkrt_pkg::cfg_t                 cfg,
    input  logic [hkrt_pkg::ACTION_W-1:0]  action,
    input  logic [hkrt_pkg::SAMPLE_W-1:0]  sample,
    output hkrt_pkg::key_state_t           nxt,
    output logic                           connected
);

    logic signed [9:0] now_s;
    logic signed [9:0] old_s;
    logic signed [9:0] td_s;
    logic signed [9:0] jl_s;
    logic signed [9:0] base_s;
    logic signed [9:0] act_s;
    logic signed [9:0] peak_s;
    logic signed [9:0] trough_s;
    logic [7:0]        idle_inc;
    logic [7:0]        press_inc;
    logic [7:0]        rel_inc;
    logic [7:0]        pcand;
    logic [7:0]        tcand;

    assign now_s    = {2'b00, sample};
    assign old_s    = {2'b00, cur.prev_sample};
    assign td_s     = {2'b00, cfg.trigger_distance};
    assign jl_s     = {2'b00, cfg.jump_limit};
    assign base_s   = {2'b00, cur.baseline};
    assign act_s    = {2'b00, cur.actuation_point};
    assign idle_inc = cur.idle_count + 8'd1;
    assign press_inc = cur.press_count + 8'd1;
    assign rel_inc  = cur.release_count + 8'd1;
    assign pcand    = (cur.press_count == 8'd0) ? cur.prev_sample : cur.peak_candidate;
    assign tcand    = (cur.release_count == 8'd0) ? cur.prev_sample : cur.trough_candidate;

    always_comb
    begin
        nxt       = cur;
        connected = 1'b1;
        peak_s    = {2'b00, cur.peak};
        trough_s  = {2'b00, cur.trough};
        unique case (action)
            hkrt_pkg::ACT_SCAN:
            begin
                nxt.prev_sample = sample;
                if (sample > hkrt_pkg::CONNECT_LIMIT)
                begin
                    connected = 1'b0;
                end
                else if (!cfg.rapid_enable)
                begin
                    nxt.key_down = ((base_s - now_s) >= act_s);
                end
                else if (sample == cur.prev_sample)
                begin
                    nxt.idle_count = idle_inc;
                    if (cur.motion_state != hkrt_pkg::MOT_IDLE &&
                        idle_inc >= cfg.idle_runs)
                    begin
                        nxt.idle_count   = 8'd0;
                        nxt.motion_state = hkrt_pkg::MOT_IDLE;
                        nxt.peak         = sample;
                        nxt.trough       = sample;
                    end
                end
                else if (sample < cur.prev_sample)
                begin
                    nxt.idle_count     = 8'd0;
                    nxt.peak_candidate = pcand;
                    nxt.press_count    = press_inc;
                    if (cur.motion_state != hkrt_pkg::MOT_PRESS &&
                        (press_inc >= cfg.direction_runs || (old_s - now_s) > jl_s))
                    begin
                        nxt.release_count = 8'd0;
                        nxt.motion_state  = hkrt_pkg::MOT_PRESS;
                        nxt.peak          = pcand;
                        peak_s            = {2'b00, pcand};
                    end
                    if ((peak_s - now_s) >= td_s)
                    begin
                        nxt.key_down = 1'b1;
                    end
                end
                else
                begin
                    nxt.idle_count       = 8'd0;
                    nxt.trough_candidate = tcand;
                    nxt.release_count    = rel_inc;
                    if (cur.motion_state != hkrt_pkg::MOT_RELEASE &&
                        (rel_inc >= cfg.direction_runs || (now_s - old_s) > jl_s))
                    begin
                        nxt.press_count  = 8'd0;
                        nxt.motion_state = hkrt_pkg::MOT_RELEASE;
                        nxt.trough       = tcand;
                        trough_s         = {2'b00, tcand};
                    end
                    if ((now_s - trough_s) >= td_s || now_s >= (base_s - td_s))
                    begin
                        nxt.key_down = 1'b0;
                    end
                end
            end
            hkrt_pkg::ACT_BASE:
            begin
                nxt.baseline = sample;
            end
            hkrt_pkg::ACT_ACTU:
            begin
                nxt.actuation_point = sample;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

FILE: tb/sv/tb_hall_key_rapid_trigger.sv
`timescale 1ns / 1ps

// Self-checking bench for the rapid-trigger key tracker.
// Items are queued by the stimulus process and handed to the block by a
// clocked driver; a clocked monitor takes the result items and compares
// them with the reports that the tracker model below worked out when each
// item was accepted.
module tb_hall_key_rapid_trigger;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    localparam int MAX_WAIT     = 11;
    localparam int CHOKE_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int NUM_KEYS     = hkrt_pkg::ROWS_DEF * hkrt_pkg::KEYS_DEF;
    localparam int PHASE_ITEMS  = 70;
    localparam int NUM_PHASES   = 6;

    // The action code that the block leaves unused.
    localparam logic [hkrt_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [hkrt_pkg::ACTION_W-1:0] action;
        logic [hkrt_pkg::ROW_W-1:0]    row;
        logic [hkrt_pkg::COL_W-1:0]    column;
        logic [hkrt_pkg::SAMPLE_W-1:0] sample;
    } key_item_t;

    typedef struct packed {
        logic [hkrt_pkg::ROW_W-1:0] row;
        logic [hkrt_pkg::COL_W-1:0] column;
        logic                       pressed;
        hkrt_pkg::motion_t          motion;
        logic                       connected;
    } key_report_t;

    // Every input of the block holds a known value from time zero.
    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [hkrt_pkg::ACTION_W-1:0]  action = hkrt_pkg::ACT_SCAN;
    logic [hkrt_pkg::ROW_W-1:0]     row = '0;
    logic [hkrt_pkg::COL_W-1:0]     column = '0;
    logic [hkrt_pkg::SAMPLE_W-1:0]  sample = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [hkrt_pkg::ROW_W-1:0]     row_out;
    logic [hkrt_pkg::COL_W-1:0]     column_out;
    logic                           pressed;
    logic [1:0]                     motion;
    logic                           connected;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [hkrt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [hkrt_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    // Tracker model: a copy of every key's entry and of the registers.
    hkrt_pkg::key_state_t key_table [NUM_KEYS];
    hkrt_pkg::cfg_t       tuning;

    key_item_t   pending_items [$];
    key_report_t awaited_reports [$];
    key_item_t   offered;
    logic        offering = 1'b0;
    int          send_gap = 0;
    int          sink_wait = 0;
    int          src_max_gap = 0;
    int          sink_max_stall = 0;
    int          choke_asked = 0;
    int          choke_served = 0;
    int          choke_left = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    key_report_t want;
    key_report_t seen;

    hall_key_rapid_trigger u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .row        (row),
        .column     (column),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .row_out    (row_out),
        .column_out (column_out),
        .pressed    (pressed),
        .motion     (motion),
        .connected  (connected),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Applies one accepted item to the model and returns the report that the
    // block must give for it. All travel arithmetic is done on signed
    // integers so that nothing wraps, while the run counters deliberately
    // wrap at eight bits as the hardware's do.
    function automatic key_report_t track_key(key_item_t it);
        key_report_t rep;
        int          k;
        int          was;
        int          now;
        int          travel;
        k      = int'({it.row, it.column});
        was    = int'(key_table[k].prev_sample);
        now    = int'(it.sample);
        travel = int'(tuning.trigger_distance);
        rep.row       = it.row;
        rep.column    = it.column;
        rep.connected = 1'b1;
        case (it.action)
            hkrt_pkg::ACT_SCAN:
            begin
                if (it.sample > hkrt_pkg::CONNECT_LIMIT)
                begin
                    // A floating sensor reads high; only the raw byte is kept.
                    rep.connected = 1'b0;
                end
                else if (!tuning.rapid_enable)
                begin
                    key_table[k].key_down = (int'(key_table[k].baseline) - now >=
                                             int'(key_table[k].actuation_point));
                end
                else if (now == was)
                begin
                    key_table[k].idle_count = key_table[k].idle_count + 8'd1;
                    if (key_table[k].motion_state != hkrt_pkg::MOT_IDLE &&
                        key_table[k].idle_count >= tuning.idle_runs)
                    begin
                        key_table[k].idle_count   = '0;
                        key_table[k].motion_state = hkrt_pkg::MOT_IDLE;
                        key_table[k].peak         = it.sample;
                        key_table[k].trough       = it.sample;
                    end
                end
                else if (now < was)
                begin
                    // Moving down: the key is being pressed.
                    key_table[k].idle_count = '0;
                    if (key_table[k].press_count == 8'd0)
                        key_table[k].peak_candidate = key_table[k].prev_sample;
                    key_table[k].press_count = key_table[k].press_count + 8'd1;
                    if (key_table[k].motion_state != hkrt_pkg::MOT_PRESS &&
                        (key_table[k].press_count >= tuning.direction_runs ||
                         was - now > int'(tuning.jump_limit)))
                    begin
                        key_table[k].release_count = '0;
                        key_table[k].motion_state  = hkrt_pkg::MOT_PRESS;
                        key_table[k].peak          = key_table[k].peak_candidate;
                    end
                    if (int'(key_table[k].peak) - now >= travel)
                        key_table[k].key_down = 1'b1;
                end
                else
                begin
                    // Moving up: the key is being let go.
                    key_table[k].idle_count = '0;
                    if (key_table[k].release_count == 8'd0)
                        key_table[k].trough_candidate = key_table[k].prev_sample;
                    key_table[k].release_count = key_table[k].release_count + 8'd1;
                    if (key_table[k].motion_state != hkrt_pkg::MOT_RELEASE &&
                        (key_table[k].release_count >= tuning.direction_runs ||
                         now - was > int'(tuning.jump_limit)))
                    begin
                        key_table[k].press_count  = '0;
                        key_table[k].motion_state = hkrt_pkg::MOT_RELEASE;
                        key_table[k].trough       = key_table[k].trough_candidate;
                    end
                    if (now - int'(key_table[k].trough) >= travel ||
                        now >= int'(key_table[k].baseline) - travel)
                        key_table[k].key_down = 1'b0;
                end
                key_table[k].prev_sample = it.sample;
            end
            hkrt_pkg::ACT_BASE: key_table[k].baseline = it.sample;
            hkrt_pkg::ACT_ACTU: key_table[k].actuation_point = it.sample;
            default: ;
        endcase
        rep.pressed = key_table[k].key_down;
        rep.motion  = key_table[k].motion_state;
        return rep;
    endfunction

    function automatic void push_item(logic [hkrt_pkg::ACTION_W-1:0] act,
                                      logic [hkrt_pkg::ROW_W-1:0] r,
                                      logic [hkrt_pkg::COL_W-1:0] c,
                                      logic [hkrt_pkg::SAMPLE_W-1:0] s);
        key_item_t it;
        it.action = act;
        it.row    = r;
        it.column = c;
        it.sample = s;
        pending_items.push_back(it);
    endfunction

    function automatic void flag_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, what);
    endfunction

    // Queues roughly the asked number of items and returns how many it
    // queued. Most items form key strokes: an optional baseline and
    // actuation load followed by a walk of scan samples with holds,
    // reversals, sudden jumps and the odd unconnected reading. The rest are
    // random items of any action on any key.
    function automatic int queue_strokes(int wanted);
        int                         added = 0;
        int                         pos;
        int                         heading;
        int                         roll;
        int                         stride;
        logic [hkrt_pkg::ROW_W-1:0] kr;
        logic [hkrt_pkg::COL_W-1:0] kc;
        while (added < wanted)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                push_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                          4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
                added++;
            end
            else
            begin
                // A handful of favourite keys keeps their history long.
                if ($urandom_range(0, 3) != 0)
                begin
                    kr = 3'($urandom_range(0, 1));
                    kc = 4'($urandom_range(0, 3));
                end
                else
                begin
                    kr = 3'($urandom_range(0, 7));
                    kc = 4'($urandom_range(0, 15));
                end
                if ($urandom_range(0, 1) != 0)
                begin
                    push_item(hkrt_pkg::ACT_BASE, kr, kc, 8'($urandom_range(8'h50, 8'h7F)));
                    added++;
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    push_item(hkrt_pkg::ACT_ACTU, kr, kc, 8'($urandom_range(4, 8'h40)));
                    added++;
                end
                pos     = $urandom_range(8'h40, 8'h7F);
                heading = -1;
                repeat ($urandom_range(6, 18))
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 4)
                    begin
                        push_item(hkrt_pkg::ACT_SCAN, kr, kc, 8'($urandom_range(8'h80, 8'hFF)));
                    end
                    else
                    begin
                        if (roll >= 16)
                        begin
                            if (roll < 26)
                                heading = -heading;
                            stride = (roll >= 90) ? $urandom_range(15, 60) : $urandom_range(1, 6);
                            pos    = pos + heading * stride;
                            if (pos < 0 || pos > int'(hkrt_pkg::CONNECT_LIMIT))
                            begin
                                pos     = (pos < 0) ? 0 : int'(hkrt_pkg::CONNECT_LIMIT);
                                heading = -heading;
                            end
                        end
                        push_item(hkrt_pkg::ACT_SCAN, kr, kc, 8'(pos));
                    end
                    added++;
                end
            end
        end
        return added;
    endfunction

    // Writes one register; called at a rising edge, it waits an idle edge past
    // the write so that back-to-back calls never set cfg_valid twice in a step.
    task automatic write_reg(logic [hkrt_pkg::CFG_IDX_W-1:0] idx,
                             logic [hkrt_pkg::CFG_DAT_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            hkrt_pkg::REG_RAPID_ENABLE:   tuning.rapid_enable = val[0];
            hkrt_pkg::REG_TRIGGER_DIST:   tuning.trigger_distance = val;
            hkrt_pkg::REG_DIRECTION_RUNS: tuning.direction_runs = val;
            hkrt_pkg::REG_IDLE_RUNS:      tuning.idle_runs = val;
            hkrt_pkg::REG_JUMP_LIMIT:     tuning.jump_limit = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_tuning(hkrt_pkg::cfg_t plan);
        write_reg(hkrt_pkg::REG_RAPID_ENABLE, {7'd0, plan.rapid_enable});
        write_reg(hkrt_pkg::REG_TRIGGER_DIST, plan.trigger_distance);
        write_reg(hkrt_pkg::REG_DIRECTION_RUNS, plan.direction_runs);
        write_reg(hkrt_pkg::REG_IDLE_RUNS, plan.idle_runs);
        write_reg(hkrt_pkg::REG_JUMP_LIMIT, plan.jump_limit);
    endtask

    // Every item yields a result, so the block is idle once nothing is
    // queued, nothing is on offer and no report is still awaited.
    task automatic settle();
        while (pending_items.size() != 0 || offering || awaited_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic drain_queue();
        while (pending_items.size() != 0)
            @(posedge clk);
    endtask

    // Driver. An item is predicted at the edge where it is accepted, then the
    // next is offered at once or after a drawn gap. in_valid is assigned once
    // per edge, so a continuous stream never drops valid between items.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                awaited_reports.push_back(track_key(offered));
                offering = 1'b0;
                send_gap = $urandom_range(0, src_max_gap);
            end
            if (!offering)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                end
                else if (pending_items.size() != 0)
                begin
                    offered  = pending_items.pop_front();
                    action   <= offered.action;
                    row      <= offered.row;
                    column   <= offered.column;
                    sample   <= offered.sample;
                    offering = 1'b1;
                end
            end
            in_valid <= offering;
        end
    end

    // A long hold-off of the receiver, counted here and started whenever the
    // stimulus raises its request count.
    always @(posedge clk)
    begin
        if (choke_asked != choke_served)
        begin
            choke_served <= choke_asked;
            choke_left   <= CHOKE_CYCLES;
        end
        else if (choke_left != 0)
        begin
            choke_left <= choke_left - 1;
        end
    end

    // Monitor. Each result item is checked against the oldest awaited report,
    // then the receiver draws how long it stalls before taking the next one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen.row       = row_out;
                seen.column    = column_out;
                seen.pressed   = pressed;
                seen.motion    = hkrt_pkg::motion_t'(motion);
                seen.connected = connected;
                if (awaited_reports.size() == 0)
                begin
                    flag_mismatch($sformatf("result r%0d c%0d with nothing awaited",
                                            row_out, column_out));
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (seen.row !== want.row || seen.column !== want.column ||
                        seen.pressed !== want.pressed || seen.motion !== want.motion ||
                        seen.connected !== want.connected)
                        flag_mismatch($sformatf(
                            "want r%0d c%0d p%0d m%0d c%0d, got r%0d c%0d p%0d m%0d c%0d",
                            want.row, want.column, want.pressed, want.motion, want.connected,
                            seen.row, seen.column, seen.pressed, seen.motion, seen.connected));
                end
                sink_wait = $urandom_range(0, sink_max_stall);
            end
            if (choke_left != 0)
            begin
                out_stall <= 1'b1;
            end
            else if (sink_wait != 0)
            begin
                sink_wait--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("hall_key_rapid_trigger: mismatch");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin
        hkrt_pkg::cfg_t plan;
        int             done;
        foreach (key_table[i])
            key_table[i] = '0;
        tuning.rapid_enable     = hkrt_pkg::RAPID_ENABLE_RST;
        tuning.trigger_distance = hkrt_pkg::TRIGGER_DIST_RST;
        tuning.direction_runs   = hkrt_pkg::DIRECTION_RUNS_RST;
        tuning.idle_runs        = hkrt_pkg::IDLE_RUNS_RST;
        tuning.jump_limit       = hkrt_pkg::JUMP_LIMIT_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        src_max_gap    <= MAX_WAIT;
        sink_max_stall <= MAX_WAIT;

        // Directed part, rapid-trigger mode with the registers at reset.
        // Loads at the far corner of the matrix with extreme bytes, and the
        // spare action code, which must leave the key alone.
        push_item(hkrt_pkg::ACT_BASE, 3'd7, 4'd15, 8'hFF);
        push_item(hkrt_pkg::ACT_ACTU, 3'd7, 4'd15, 8'h00);
        push_item(ACT_SPARE, 3'd3, 4'd5, 8'hA5);
        push_item(hkrt_pkg::ACT_BASE, 3'd0, 4'd0, 8'h70);
        // Unconnected readings just above the limit and at the top.
        push_item(hkrt_pkg::ACT_SCAN, 3'd0, 4'd0, 8'h80);
        push_item(hkrt_pkg::ACT_SCAN, 3'd0, 4'd0, 8'hFF);
        // A fall far larger than the jump limit confirms pressing at once.
        push_item(hkrt_pkg::ACT_SCAN, 3'd0, 4'd0, 8'h70);
        push_item(hkrt_pkg::ACT_SCAN, 3'd0, 4'd0, 8'h68);
        push_item(hkrt_pkg::ACT_SCAN, 3'd0, 4'd0, 8'h50);
        push_item(hkrt_pkg::ACT_SCAN, 3'd0, 4'd0, 8'h30);
        push_item(hkrt_pkg::ACT_SCAN, 3'd0, 4'd0, 8'h30);
        // Slow rise: release confirmed by runs, key let go at once from a zero trough.
        push_item(hkrt_pkg::ACT_SCAN, 3'd0, 4'd0, 8'h33);
        push_item(hkrt_pkg::ACT_SCAN, 3'd0, 4'd0, 8'h36);
        push_item(hkrt_pkg::ACT_SCAN, 3'd0, 4'd0, 8'h3C);
        // Slow fall back down: pressed again at once, measured from the old peak.
        push_item(hkrt_pkg::ACT_SCAN, 3'd0, 4'd0, 8'h39);
        push_item(hkrt_pkg::ACT_SCAN, 3'd0, 4'd0, 8'h35);
        push_item(hkrt_pkg::ACT_SCAN, 3'd0, 4'd0, 8'h31);
        // A sudden rise near the baseline.
        push_item(hkrt_pkg::ACT_SCAN, 3'd0, 4'd0, 8'h6A);
        push_item(hkrt_pkg::ACT_SCAN, 3'd0, 4'd0, 8'h6A);
        settle();

        // Fixed actuation point: just short of it, exactly on it, full
        // travel, and a sample above the baseline where the difference
        // goes negative.
        write_reg(hkrt_pkg::REG_RAPID_ENABLE, 8'd0);
        push_item(hkrt_pkg::ACT_BASE, 3'd2, 4'd9, 8'h60);
        push_item(hkrt_pkg::ACT_ACTU, 3'd2, 4'd9, 8'h20);
        push_item(hkrt_pkg::ACT_SCAN, 3'd2, 4'd9, 8'h41);
        push_item(hkrt_pkg::ACT_SCAN, 3'd2, 4'd9, 8'h40);
        push_item(hkrt_pkg::ACT_SCAN, 3'd2, 4'd9, 8'h00);
        push_item(hkrt_pkg::ACT_SCAN, 3'd2, 4'd9, 8'h7F);
        settle();

        // Random part, one register setting per phase.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: plan = '{1'b1, hkrt_pkg::TRIGGER_DIST_RST, hkrt_pkg::DIRECTION_RUNS_RST,
                            hkrt_pkg::IDLE_RUNS_RST, hkrt_pkg::JUMP_LIMIT_RST};
                1: plan = '{1'b1, 8'd0, 8'd0, 8'd0, 8'd0};
                2: plan = '{1'b1, 8'd255, 8'd255, 8'd255, 8'd255};
                3: plan = '{1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
                4: plan = '{1'b1, 8'($urandom_range(2, 20)), 8'($urandom_range(1, 4)),
                            8'($urandom_range(1, 6)), 8'($urandom_range(4, 40))};
                default: plan = '{1'b1, 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255))};
            endcase
            settle();
            set_tuning(plan);

            if (ph == 4)
            begin
                // Back-pressure: the receiver holds off for a long stretch while
                // the sender streams without gaps, so the block fills and stalls.
                src_max_gap    <= 0;
                sink_max_stall <= 0;
                choke_asked    <= choke_asked + 1;
                void'(queue_strokes(40));
                drain_queue();
                settle();
            end

            done = 0;
            while (done < PHASE_ITEMS)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        src_max_gap    <= 0;
                        sink_max_stall <= 0;
                    end
                    1:
                    begin
                        src_max_gap    <= MAX_WAIT;
                        sink_max_stall <= 0;
                    end
                    2:
                    begin
                        src_max_gap    <= 0;
                        sink_max_stall <= MAX_WAIT;
                    end
                    default:
                    begin
                        src_max_gap    <= MAX_WAIT;
                        sink_max_stall <= MAX_WAIT;
                    end
                endcase
                done += queue_strokes($urandom_range(10, 30));
                drain_queue();
                // Now and then the sender waits until every result is back.
                if ($urandom_range(0, 1) != 0)
                    settle();
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("hall_key_rapid_trigger: match");
        else
            $display("hall_key_rapid_trigger: mismatch");
        $finish;
    end

endmodule
